[sv/rotary_encoder_button_qualifier_top_defines.svh]
// ----------------------------------------------------------------------------
// Rotary encoder button qualifier - assertion macros
// Shared concurrent assertion forms used at the top level.
// ----------------------------------------------------------------------------
`ifndef ROTARY_ENCODER_BUTTON_QUALIFIER_TOP_DEFINES_SVH
`define ROTARY_ENCODER_BUTTON_QUALIFIER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define REBQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rebq assertion failed");

// next-cycle implication, disabled in reset
`define REBQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rebq assertion failed");

`endif

[sv/rebq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rebq_pkg
// Types and constants of the rotary encoder button qualifier.
// ----------------------------------------------------------------------------
package rebq_pkg;

  localparam int TIMER_WIDTH    = 24;
  localparam int POSITION_WIDTH = 16;

  localparam int CFG_TICK_W  = 24;
  localparam int CFG_LIMIT_W = 15;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_DATA_W   = 8;

  localparam logic [CFG_TICK_W-1:0]  RST_DEBOUNCE   = 24'd50000;
  localparam logic [CFG_TICK_W-1:0]  RST_LONG_PRESS = 24'd1000000;
  localparam logic [CFG_TICK_W-1:0]  RST_LOCKOUT    = 24'd1000;
  localparam logic [CFG_LIMIT_W-1:0] RST_LIMIT      = 15'd100;

  // {previous CLK, current CLK}
  localparam logic [1:0] FALLING = 2'b10;

  typedef enum logic [1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_LOCKOUT    = 2'd2,
    REG_LIMIT      = 2'd3
  } rebq_reg_t;

  typedef struct packed {
    logic [CFG_TICK_W-1:0]  debounce_ticks;
    logic [CFG_TICK_W-1:0]  long_press_ticks;
    logic [CFG_TICK_W-1:0]  lockout_ticks;
    logic [CFG_LIMIT_W-1:0] position_limit;
  } rebq_cfg_t;

  // lowest bit last: switch_level sits at bit 0
  typedef struct packed {
    logic take_long_press;
    logic resync_switch;
    logic clear_position;
    logic count_enable;
    logic clock_level;
    logic dir_level;
    logic switch_level;
  } rebq_item_t;

  typedef struct packed {
    logic long_press_waiting;
    logic long_press_taken;
    logic button_down;
  } rebq_flags_t;

endpackage

[sv/rotary_encoder_button_qualifier_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_encoder_button_qualifier_top
// Rotary encoder position counter with debounced push button and long press.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per time-base tick with sampled switch, DT and CLK pin
//           levels plus the control flags.
//   out_* : one word per input word: position, button state, long-press
//           taken and long-press waiting after that tick.
//   cfg_* : APB-style register port; debounce, long press and lockout tick
//           counts at 0x0, 0x4, 0x8 and the position limit at 0xC.
// Timing:
//   A word is registered in the input register, then the state update
//   writes the output register, which drives out_tvalid and out_tdata.
//   One word per cycle while out_tready is high, set by the state update loop.
// Reset:
//   Synchronous, active low. Position and timers clear, button released,
//   no long press pending, registers take their default values.
// Backpressure:
//   With out_tready low the result holds, one more word is taken into the
//   input register, then in_tready drops until the output is drained.
// ----------------------------------------------------------------------------
`include "rotary_encoder_button_qualifier_top_defines.svh"

module rotary_encoder_button_qualifier_top #(
  parameter int TIMER_WIDTH    = rebq_pkg::TIMER_WIDTH,
  parameter int POSITION_WIDTH = rebq_pkg::POSITION_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // switch_level, dir_level, clock_level, count_enable, clear_position,
  // resync_switch, take_long_press, pad
  input  logic [rebq_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // position, button_down, long_press_taken, long_press_waiting, pad
  output logic [((POSITION_WIDTH+3+7)/8)*8-1:0] out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [rebq_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [rebq_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [rebq_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  localparam int OUT_W = ((POSITION_WIDTH + 3 + 7) / 8) * 8;
  localparam logic [POSITION_WIDTH-1:0] POS_MIN_CODE =
    {1'b1, {(POSITION_WIDTH-1){1'b0}}};

  rebq_pkg::rebq_cfg_t   cfg;
  rebq_pkg::rebq_item_t  item_r, item_nxt;
  rebq_pkg::rebq_flags_t flags;
  logic                  in_vld_r, in_vld_nxt;
  logic                  out_vld_r, out_vld_nxt;
  logic [OUT_W-1:0]      out_data_r, out_data_nxt;
  logic signed [POSITION_WIDTH-1:0] position;
  logic                  adv;

  rebq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  rebq_core #(
    .TIMER_WIDTH    (TIMER_WIDTH),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (adv),
    .item     (item_r),
    .cfg      (cfg),
    .position (position),
    .flags    (flags)
  );

  assign adv       = in_vld_r & (~out_vld_r | out_tready);
  assign in_tready = ~in_vld_r | adv;

  always_comb begin
    in_vld_nxt = in_vld_r;
    item_nxt   = item_r;
    if (in_tvalid && in_tready) begin
      in_vld_nxt = 1'b1;
      item_nxt   = rebq_pkg::rebq_item_t'(in_tdata[6:0]);
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    if (adv) begin
      out_vld_nxt  = 1'b1;
      out_data_nxt = OUT_W'({flags.long_press_waiting, flags.long_press_taken,
                             flags.button_down, position});
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  `REBQ_ASSERT_IMP(a_stall_cause, clk, rst_n, !in_tready, in_vld_r && out_tvalid && !out_tready)
  `REBQ_ASSERT_NXT(a_adv_result, clk, rst_n, in_vld_r && (!out_tvalid || out_tready), out_tvalid)
  `REBQ_ASSERT_IMP(a_pos_range, clk, rst_n, out_tvalid, out_tdata[POSITION_WIDTH-1:0] != POS_MIN_CODE)
  `REBQ_ASSERT_IMP(a_take_clears, clk, rst_n, out_tvalid && out_tdata[POSITION_WIDTH+1], !out_tdata[POSITION_WIDTH+2])

endmodule

[sv/rebq_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rebq_cfg
// APB-style register file holding the four configuration registers.
// ----------------------------------------------------------------------------
module rebq_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rebq_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rebq_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rebq_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output rebq_pkg::rebq_cfg_t             cfg
);

  rebq_pkg::rebq_cfg_t cfg_r;
  rebq_pkg::rebq_cfg_t cfg_nxt;
  rebq_pkg::rebq_reg_t idx;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = rebq_pkg::rebq_reg_t'(paddr[rebq_pkg::CFG_ADDR_W-1:2]);
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        rebq_pkg::REG_DEBOUNCE:
          cfg_nxt.debounce_ticks = pwdata[rebq_pkg::CFG_TICK_W-1:0];
        rebq_pkg::REG_LONG_PRESS:
          cfg_nxt.long_press_ticks = pwdata[rebq_pkg::CFG_TICK_W-1:0];
        rebq_pkg::REG_LOCKOUT:
          cfg_nxt.lockout_ticks = pwdata[rebq_pkg::CFG_TICK_W-1:0];
        rebq_pkg::REG_LIMIT:
          cfg_nxt.position_limit = pwdata[rebq_pkg::CFG_LIMIT_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rebq_pkg::REG_DEBOUNCE:   prdata = rebq_pkg::CFG_DATA_W'(cfg_r.debounce_ticks);
      rebq_pkg::REG_LONG_PRESS: prdata = rebq_pkg::CFG_DATA_W'(cfg_r.long_press_ticks);
      rebq_pkg::REG_LOCKOUT:    prdata = rebq_pkg::CFG_DATA_W'(cfg_r.lockout_ticks);
      rebq_pkg::REG_LIMIT:      prdata = rebq_pkg::CFG_DATA_W'(cfg_r.position_limit);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= rebq_pkg::RST_DEBOUNCE;
      cfg_r.long_press_ticks <= rebq_pkg::RST_LONG_PRESS;
      cfg_r.lockout_ticks    <= rebq_pkg::RST_LOCKOUT;
      cfg_r.position_limit   <= rebq_pkg::RST_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[sv/rebq_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rebq_core
// Per-tick update of debounce, long-press and position state.
// ----------------------------------------------------------------------------
module rebq_core #(
  parameter int TIMER_WIDTH    = rebq_pkg::TIMER_WIDTH,
  parameter int POSITION_WIDTH = rebq_pkg::POSITION_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step,
  input  rebq_pkg::rebq_item_t             item,
  input  rebq_pkg::rebq_cfg_t              cfg,
  output logic signed [POSITION_WIDTH-1:0] position,
  output rebq_pkg::rebq_flags_t            flags
);

  localparam int CMP_W = (TIMER_WIDTH > rebq_pkg::CFG_TICK_W) ?
                         TIMER_WIDTH : rebq_pkg::CFG_TICK_W;
  localparam int LIM_W = ((POSITION_WIDTH > rebq_pkg::CFG_LIMIT_W + 1) ?
                          POSITION_WIDTH : rebq_pkg::CFG_LIMIT_W + 1) + 1;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;
  localparam logic signed [LIM_W-1:0] POS_MAX =
    $signed(LIM_W'({(POSITION_WIDTH-1){1'b1}}));

  logic signed [POSITION_WIDTH-1:0] pos_r, pos_nxt;
  logic                             deb_r, deb_nxt;
  logic                             last_raw_r, last_raw_nxt;
  logic [TIMER_WIDTH-1:0]           stable_r, stable_nxt;
  logic [TIMER_WIDTH-1:0]           press_r, press_nxt;
  logic [TIMER_WIDTH-1:0]           edge_r, edge_nxt;
  logic                             fired_r, fired_nxt;
  logic                             pending_r, pending_nxt;
  logic                             prev_clk_r, prev_clk_nxt;
  logic                             taken;

  logic [TIMER_WIDTH-1:0]    stable_up, press_up, edge_up;
  logic signed [LIM_W-1:0]   lim_cfg, lim, neg_lim, pos_ext;
  logic                      edge_hit;

  assign stable_up = (stable_r == TIMER_MAX) ? stable_r : stable_r + 1'b1;
  assign press_up  = (press_r == TIMER_MAX) ? press_r : press_r + 1'b1;
  assign edge_up   = (edge_r == TIMER_MAX) ? edge_r : edge_r + 1'b1;

  assign lim_cfg = $signed(LIM_W'(cfg.position_limit));
  assign lim     = (lim_cfg > POS_MAX) ? POS_MAX : lim_cfg;
  assign neg_lim = -lim;

  assign edge_hit = ({prev_clk_r, item.clock_level} == rebq_pkg::FALLING) &&
                    item.count_enable &&
                    (CMP_W'(edge_up) >= CMP_W'(cfg.lockout_ticks));

  always_comb begin
    pos_nxt      = pos_r;
    deb_nxt      = deb_r;
    last_raw_nxt = last_raw_r;
    stable_nxt   = stable_r;
    press_nxt    = press_r;
    edge_nxt     = edge_r;
    fired_nxt    = fired_r;
    pending_nxt  = pending_r;
    prev_clk_nxt = prev_clk_r;
    taken        = 1'b0;
    pos_ext      = '0;
    if (step) begin
      stable_nxt = stable_up;
      press_nxt  = press_up;
      edge_nxt   = edge_up;
      if (item.resync_switch) begin
        deb_nxt      = item.switch_level;
        last_raw_nxt = item.switch_level;
        stable_nxt   = '0;
        fired_nxt    = ~item.switch_level;
      end else begin
        if (item.switch_level != last_raw_r) begin
          stable_nxt = '0;
        end
        if (CMP_W'(stable_nxt) > CMP_W'(cfg.debounce_ticks)) begin
          if (item.switch_level != deb_r) begin
            deb_nxt = item.switch_level;
            if (!item.switch_level) begin
              pos_nxt   = '0;
              press_nxt = '0;
              fired_nxt = 1'b0;
            end
          end
          if (!deb_nxt && !fired_nxt &&
              (CMP_W'(press_nxt) > CMP_W'(cfg.long_press_ticks))) begin
            fired_nxt   = 1'b1;
            pending_nxt = 1'b1;
          end
        end
        last_raw_nxt = item.switch_level;
      end
      if (item.clear_position) begin
        pos_nxt = '0;
      end
      if (edge_hit) begin
        edge_nxt = '0;
        pos_ext  = LIM_W'(pos_nxt);
        if (item.dir_level) begin
          if (pos_ext < lim) pos_nxt = pos_nxt + POSITION_WIDTH'(1);
        end else begin
          if (pos_ext > neg_lim) pos_nxt = pos_nxt - POSITION_WIDTH'(1);
        end
      end
      prev_clk_nxt = item.clock_level;
      if (item.take_long_press && pending_nxt) begin
        pending_nxt = 1'b0;
        taken       = 1'b1;
      end
    end
  end

  assign position                 = pos_nxt;
  assign flags.button_down        = ~deb_nxt;
  assign flags.long_press_taken   = taken;
  assign flags.long_press_waiting = pending_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      deb_r      <= 1'b1;
      last_raw_r <= 1'b1;
      stable_r   <= '0;
      press_r    <= '0;
      edge_r     <= '0;
      fired_r    <= 1'b0;
      pending_r  <= 1'b0;
      prev_clk_r <= 1'b1;
    end else begin
      pos_r      <= pos_nxt;
      deb_r      <= deb_nxt;
      last_raw_r <= last_raw_nxt;
      stable_r   <= stable_nxt;
      press_r    <= press_nxt;
      edge_r     <= edge_nxt;
      fired_r    <= fired_nxt;
      pending_r  <= pending_nxt;
      prev_clk_r <= prev_clk_nxt;
    end
  end

endmodule
